// ----- sv/bmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_pkg
// shared types and constants of the bus mouse port controller
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

  // item operations
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_MOTION = 2'd2,
    OP_TICK   = 2'd3
  } opcode_t;

  // byte ports of the parallel interface
  typedef enum logic [1:0] {
    PORT_DATA = 2'd0,
    PORT_SIG  = 2'd1,
    PORT_CTL  = 2'd2,
    PORT_MODE = 2'd3
  } port_t;

  // control port bit positions
  localparam int unsigned CTL_INT_DIS  = 4;
  localparam int unsigned CTL_SEL_HIGH = 5;
  localparam int unsigned CTL_SEL_Y    = 6;
  localparam int unsigned CTL_HOLD     = 7;

  localparam logic [7:0] CTL_RESET  = 8'h10;
  localparam logic [7:0] MODE_RESET = 8'h91;

  localparam int unsigned TOGGLE_W = 10;
  localparam logic [TOGGLE_W-1:0] TOGGLE_RELOAD = 10'd1000;

  localparam int unsigned COUNTDOWN_W = 4;
  localparam logic [COUNTDOWN_W-1:0] DISABLE_TICKS = 4'd8;

  localparam logic [2:0] IRQ_SEL_RESET = 3'd3;

  // accumulator commands from the port logic to one axis
  typedef struct packed {
    logic add;    // host motion adds delta
    logic latch;  // hold edge subtracts the clamped value
  } acc_cmd_t;

endpackage

`default_nettype wire

// ----- sv/bmp_cfg.sv -----
// ----------------------------------------------------------------------------
// bmp_cfg
// apb register for the jumpered interrupt level, decoded to a port c mask
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  irq_mask
);
  import bmp_pkg::*;

  logic [2:0] irq_sel_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_sel_r <= IRQ_SEL_RESET;
    end else if (wr_en) begin
      irq_sel_r <= pwdata[2:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {29'd0, irq_sel_r} : 32'd0;

  // level saturates to 2..5, bit index is 5 - level
  always_comb begin
    case (irq_sel_r)
      3'd0, 3'd1, 3'd2: irq_mask = 8'h08;
      3'd3:             irq_mask = 8'h04;
      3'd4:             irq_mask = 8'h02;
      default:          irq_mask = 8'h01;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/bmp_axis.sv -----
// ----------------------------------------------------------------------------
// bmp_axis
// one saturating 32-bit motion accumulator with clamp-and-subtract on hold
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_axis (
  input  logic                clk,
  input  logic                rst_n,
  input  bmp_pkg::acc_cmd_t   cmd,
  input  logic signed [15:0]  delta,
  output logic [7:0]          clamp_byte
);
  import bmp_pkg::*;

  logic signed [31:0] accum_r;
  logic signed [31:0] accum_nxt;
  logic signed [32:0] sum;
  logic signed [31:0] clamp_ext;

  // clamp to -128..127
  always_comb begin
    if (accum_r < -32'sd128) begin
      clamp_byte = 8'h80;
    end else if (accum_r > 32'sd127) begin
      clamp_byte = 8'h7F;
    end else begin
      clamp_byte = accum_r[7:0];
    end
  end

  assign clamp_ext = {{24{clamp_byte[7]}}, clamp_byte};
  assign sum       = {accum_r[31], accum_r} + {{17{delta[15]}}, delta};

  always_comb begin
    accum_nxt = accum_r;
    if (cmd.add) begin
      if (sum[32] != sum[31]) begin
        // overflow, pin at the signed limit
        accum_nxt = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        accum_nxt = sum[31:0];
      end
    end else if (cmd.latch) begin
      accum_nxt = accum_r - clamp_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else begin
      accum_r <= accum_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bus_mouse_port_controller.sv -----
// ----------------------------------------------------------------------------
// bus_mouse_port_controller
// bus mouse adapter: four byte ports, motion accumulators, timer interrupt
// ----------------------------------------------------------------------------
// result: each result word is registered in the output register when its input
//   word is taken
// throughput: one word per cycle; all state updates at the accept edge, so
//   the next word sees them at once; in_ready only drops while a result waits
// reset: synchronous active-low rst_n returns all ports and counters to their
//   power-on values (control 0x10, mode 0x91, read toggle count 1000)
// ----------------------------------------------------------------------------
`default_nettype none

module bus_mouse_port_controller (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [1:0]         in_port_offset,
  input  logic [7:0]         in_write_data,
  input  logic signed [15:0] in_motion_dx,
  input  logic signed [15:0] in_motion_dy,
  input  logic [2:0]         in_button_bits,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_read_data,
  output logic               out_irq_line,
  output logic               out_mouse_active,
  output logic               out_active_changed,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bmp_pkg::*;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [7:0] irq_mask;

  bmp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .irq_mask (irq_mask)
  );

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  logic [7:0]             data_r,   data_nxt;
  logic [7:0]             sig_r,    sig_nxt;
  logic [7:0]             ctl_r,    ctl_nxt;
  logic [7:0]             mode_r,   mode_nxt;
  logic                   held_r,   held_nxt;
  logic [7:0]             held_x_r, held_x_nxt;
  logic [7:0]             held_y_r, held_y_nxt;
  logic [2:0]             btn_r,    btn_nxt;
  logic [TOGGLE_W-1:0]    tog_r,    tog_nxt;
  logic [COUNTDOWN_W-1:0] cd_r,     cd_nxt;
  logic                   en_r,     en_nxt;
  logic                   irq_r,    irq_nxt;

  logic [7:0] rd_nxt;
  logic       chg_nxt;

  logic       out_valid_r;
  logic [7:0] out_rd_r;
  logic       out_irq_r;
  logic       out_act_r;
  logic       out_chg_r;

  logic       accept;
  acc_cmd_t   cmd;
  logic [7:0] clamp_x;
  logic [7:0] clamp_y;

  // result register parts the two sides
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // motion accumulators
  // --------------------------------------------------------------------------
  bmp_axis u_axis_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .delta      (in_motion_dx),
    .clamp_byte (clamp_x)
  );

  bmp_axis u_axis_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .delta      (in_motion_dy),
    .clamp_byte (clamp_y)
  );

  // --------------------------------------------------------------------------
  // per-word port logic
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0] sel_byte;
    logic [7:0] nib;
    logic       int_en;

    data_nxt   = data_r;
    sig_nxt    = sig_r;
    ctl_nxt    = ctl_r;
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    btn_nxt    = btn_r;
    tog_nxt    = tog_r;
    cd_nxt     = cd_r;
    en_nxt     = en_r;
    irq_nxt    = irq_r;
    rd_nxt     = 8'd0;
    chg_nxt    = 1'b0;
    cmd        = '0;
    sel_byte   = 8'd0;
    nib        = 8'd0;
    int_en     = !ctl_r[CTL_INT_DIS];

    if (accept) begin
      case (opcode_t'(in_opcode))
        OP_READ: begin
          case (port_t'(in_port_offset))
            PORT_DATA: rd_nxt = data_r;
            PORT_SIG:  rd_nxt = sig_r;
            PORT_CTL: begin
              rd_nxt = ctl_r;
              // every 1001st control read shows the interrupt bit flipped
              if (tog_r != '0) begin
                tog_nxt = tog_r - 1'b1;
              end else begin
                tog_nxt = TOGGLE_RELOAD;
                rd_nxt  = ctl_r ^ irq_mask;
              end
            end
            default: rd_nxt = mode_r;
          endcase
        end

        OP_WRITE: begin
          case (port_t'(in_port_offset))
            PORT_SIG:  sig_nxt  = in_write_data;
            PORT_MODE: mode_nxt = in_write_data;
            PORT_CTL: begin
              ctl_nxt = {in_write_data[7:4], ctl_r[3:0]};
              // hold edge latches clamped counters
              if (ctl_nxt[CTL_HOLD]) begin
                if (!held_r) begin
                  held_nxt   = 1'b1;
                  cmd.latch  = 1'b1;
                  held_x_nxt = clamp_x;
                  held_y_nxt = clamp_y;
                end
              end else begin
                held_nxt = 1'b0;
              end
              // port a only refreshes while held
              if (held_nxt) begin
                sel_byte = ctl_nxt[CTL_SEL_Y] ? held_y_nxt : held_x_nxt;
                nib      = ctl_nxt[CTL_SEL_HIGH] ? {4'd0, sel_byte[7:4]}
                                                 : {4'd0, sel_byte[3:0]};
                // active-low buttons: left bit 7, middle bit 6, right bit 5
                nib[7]   = !btn_r[0];
                nib[5]   = !btn_r[1];
                nib[6]   = !btn_r[2];
                data_nxt = nib;
              end
              // interrupt disable drops the line and clears the bit
              if (ctl_nxt[CTL_INT_DIS]) begin
                irq_nxt = 1'b0;
                ctl_nxt = ctl_nxt & ~irq_mask;
              end
            end
            default: ; // data port writes are ignored
          endcase
        end

        OP_MOTION: begin
          cmd.add = 1'b1;
          btn_nxt = in_button_bits;
        end

        default: begin
          // timer tick: toggle interrupt bit, line follows only when enabled
          ctl_nxt = ctl_r ^ irq_mask;
          if (int_en) begin
            irq_nxt = ((ctl_r & irq_mask) == 8'd0);
            cd_nxt  = DISABLE_TICKS;
            if (!en_r) begin
              en_nxt  = 1'b1;
              chg_nxt = 1'b1;
            end
          end else begin
            if (cd_r != '0) begin
              cd_nxt = cd_r - 1'b1;
            end
            if ((cd_nxt == '0) && en_r) begin
              en_nxt  = 1'b0;
              chg_nxt = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // state and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r      <= 8'd0;
      sig_r       <= 8'd0;
      ctl_r       <= CTL_RESET;
      mode_r      <= MODE_RESET;
      held_r      <= 1'b0;
      held_x_r    <= 8'd0;
      held_y_r    <= 8'd0;
      btn_r       <= 3'd0;
      tog_r       <= TOGGLE_RELOAD;
      cd_r        <= '0;
      en_r        <= 1'b0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      data_r   <= data_nxt;
      sig_r    <= sig_nxt;
      ctl_r    <= ctl_nxt;
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
      btn_r    <= btn_nxt;
      tog_r    <= tog_nxt;
      cd_r     <= cd_nxt;
      en_r     <= en_nxt;
      irq_r    <= irq_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rd_r  <= rd_nxt;
      out_irq_r <= irq_nxt;
      out_act_r <= en_nxt;
      out_chg_r <= chg_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_rd_r;
  assign out_irq_line       = out_irq_r;
  assign out_mouse_active   = out_act_r;
  assign out_active_changed = out_chg_r;

endmodule

`default_nettype wire
